### rtl/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg: shared types, constants and palette helpers for the block decoder
// Holds the request/response beat structs, format codes and the endpoint
// expansion and interpolation functions used by the front stage.
// ----------------------------------------------------------------------------
`default_nettype none
package bcd_pkg;

   localparam int unsigned QueueDepth = 2;

   typedef enum logic [2:0] {
      FMT_BC1 = 3'd0,
      FMT_BC2 = 3'd1,
      FMT_BC3 = 3'd2,
      FMT_BC4 = 3'd3,
      FMT_BC5 = 3'd4
   } fmt_type;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_type;

   typedef struct packed {
      logic [1:0]  row_index;
      logic [31:0] texel_0;
      logic [31:0] texel_1;
      logic [31:0] texel_2;
      logic [31:0] texel_3;
      logic        last_row;
   } rsp_type;

   // Classified block: palettes plus raw indices, handed from front to back.
   typedef struct packed {
      logic [2:0]       fmt;
      logic [3:0][31:0] cpal;     // colour palette, BGRA
      logic [7:0][7:0]  apal_lo;  // alpha/grey/x palette
      logic [7:0][7:0]  apal_hi;  // y palette for BC5
      logic [31:0]      cidx;
      logic [47:0]      aidx_lo;
      logic [47:0]      aidx_hi;
      logic [63:0]      nib;      // explicit BC2 alpha
   } work_type;

   function automatic logic [7:0] exp5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] exp6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   // (2a+b+1)/3 via reciprocal multiply; x <= 766
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [20:0] p;
      p = 21'(x) * 21'd683;
      return p[18:11];
   endfunction

   // x/7 for x < 1792+3
   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'd2341;
      return p[21:14];
   endfunction

   // x/5 for x <= 1275+2
   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'd3277;
      return p[21:14];
   endfunction

   function automatic logic [7:0][7:0] alpha_pal(input logic [15:0] w);
      logic [7:0][7:0] v;
      logic [7:0]      a0;
      logic [7:0]      a1;
      a0 = w[7:0];
      a1 = w[15:8];
      v[0] = a0;
      v[1] = a1;
      if (a0 > a1) begin
         for (int k = 2; k < 8; k++) begin
            v[k] = div7(11'(8 - k) * 11'(a0) + 11'(k - 1) * 11'(a1) + 11'd3);
         end
      end else begin
         for (int k = 2; k < 6; k++) begin
            v[k] = div5(11'(6 - k) * 11'(a0) + 11'(k - 1) * 11'(a1) + 11'd2);
         end
         v[6] = 8'd0;
         v[7] = 8'd255;
      end
      return v;
   endfunction

   function automatic logic [3:0][31:0] colour_pal(input logic [31:0] w,
                                                    input logic three_ok);
      logic [3:0][31:0] p;
      logic [2:0][7:0]  e0;
      logic [2:0][7:0]  e1;
      logic [2:0][7:0]  m2;
      logic [2:0][7:0]  m3;
      logic [9:0]       s;
      e0[0] = exp5(w[4:0]);   e0[1] = exp6(w[10:5]);  e0[2] = exp5(w[15:11]);
      e1[0] = exp5(w[20:16]); e1[1] = exp6(w[26:21]); e1[2] = exp5(w[31:27]);
      for (int k = 0; k < 3; k++) begin
         if (w[15:0] > w[31:16] || !three_ok) begin
            m2[k] = div3({1'b0, e0[k], 1'b0} + 10'(e1[k]) + 10'd1);
            m3[k] = div3(10'(e0[k]) + {1'b0, e1[k], 1'b0} + 10'd1);
         end else begin
            s = 10'(e0[k]) + 10'(e1[k]) + 10'd1;
            m2[k] = s[8:1];
            m3[k] = 8'd0;
         end
      end
      p[0] = {8'hFF, e0[2], e0[1], e0[0]};
      p[1] = {8'hFF, e1[2], e1[1], e1[0]};
      p[2] = {8'hFF, m2[2], m2[1], m2[0]};
      if (w[15:0] > w[31:16] || !three_ok) p[3] = {8'hFF, m3[2], m3[1], m3[0]};
      else p[3] = 32'd0;
      return p;
   endfunction

endpackage
`default_nettype wire

### rtl/bcd_front.sv
// ----------------------------------------------------------------------------
// bcd_front: block classifier
// Accepts one block per beat, builds its palettes and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none
module bcd_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire [2:0]           fmt,
   input  wire                 req_valid,
   output logic                req_stall,
   input  bcd_pkg::req_type    req_data,
   output logic                wk_valid,
   input  wire                 wk_stall,
   output bcd_pkg::work_type   wk_data
);
   import bcd_pkg::*;

   logic     valid_ff, valid_in;
   work_type data_ff, data_in;
   logic     take;
   logic [63:0] cw;

   assign req_stall = valid_ff && wk_stall;
   assign take      = req_valid && !req_stall;
   assign wk_valid  = valid_ff;
   assign wk_data   = data_ff;

   always_comb begin
      cw = (fmt == FMT_BC1) ? req_data.block_low : req_data.block_high;
      data_in.fmt     = fmt;
      data_in.cpal    = colour_pal(cw[31:0], fmt == FMT_BC1);
      data_in.cidx    = cw[63:32];
      data_in.apal_lo = alpha_pal(req_data.block_low[15:0]);
      data_in.aidx_lo = req_data.block_low[63:16];
      data_in.apal_hi = alpha_pal(req_data.block_high[15:0]);
      data_in.aidx_hi = req_data.block_high[63:16];
      data_in.nib     = req_data.block_low;
      valid_in = take ? 1'b1 : (wk_stall ? valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (take) data_ff <= data_in;
   end
endmodule
`default_nettype wire

### rtl/bcd_queue.sv
// ----------------------------------------------------------------------------
// bcd_queue: small FIFO between classifier and row emitter
// Holds classified blocks so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none
module bcd_queue #(
   parameter int unsigned Depth = bcd_pkg::QueueDepth
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_stall,
   input  bcd_pkg::work_type   in_data,
   output logic                out_valid,
   input  wire                 out_pop,
   output bcd_pkg::work_type   out_data
);
   import bcd_pkg::*;
   localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

   work_type          mem_ff [Depth];
   logic [AW-1:0]     wp_ff, rp_ff;
   logic [AW:0]       cnt_ff;
   logic              push, pop;

   assign in_stall  = (cnt_ff == (AW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rp_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_pop && out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule
`default_nettype wire

### rtl/bcd_back.sv
// ----------------------------------------------------------------------------
// bcd_back: row emitter
// Looks up four texels per row, sequencing BC5 blue through a shared
// bit-serial square root, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module bcd_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 wk_valid,
   output logic                wk_pop,
   input  bcd_pkg::work_type   wk_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output bcd_pkg::rsp_type    rsp_data
);
   import bcd_pkg::*;

   logic [1:0]  row_ff;
   logic [2:0]  tx_ff;      // texel within row for BC5 sqrt walk
   logic [3:0]  step_ff;    // sqrt iteration
   logic        busy_ff;    // sqrt running
   logic [15:0] n_ff, res_ff, bit_ff;
   logic [3:0][7:0] blue_ff;
   logic        ov_ff;
   rsp_type     out_ff;

   logic        is5, ready_row, emit;
   logic [3:0][31:0] tex;
   logic [3:0]  ti;
   logic [7:0]  x [4];
   logic [7:0]  y [4];
   logic [16:0] sq;
   logic [8:0]  dx, dy;
   logic [17:0] n;
   logic [7:0]  xs, ys;
   logic [16:0] trial;
   logic [8:0]  bsum;

   assign is5 = (wk_data.fmt == FMT_BC5);

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         ti = {row_ff, 2'(c)};
         x[c] = wk_data.apal_lo[wk_data.aidx_lo[3*ti +: 3]];
         y[c] = wk_data.apal_hi[wk_data.aidx_hi[3*ti +: 3]];
         unique case (wk_data.fmt)
            FMT_BC1: tex[c] = wk_data.cpal[wk_data.cidx[2*ti +: 2]];
            FMT_BC2: tex[c] = {wk_data.nib[4*ti +: 4], wk_data.nib[4*ti +: 4],
                               wk_data.cpal[wk_data.cidx[2*ti +: 2]][23:0]};
            FMT_BC3: tex[c] = {x[c], wk_data.cpal[wk_data.cidx[2*ti +: 2]][23:0]};
            FMT_BC4: tex[c] = {8'hFF, x[c], x[c], x[c]};
            FMT_BC5: tex[c] = {8'hFF, x[c], y[c], blue_ff[c]};
            default: tex[c] = 32'd0;
         endcase
      end
   end

   // N = 65025 - dx^2 - dy^2 for the texel being started
   always_comb begin
      xs = x[tx_ff[1:0]];
      ys = y[tx_ff[1:0]];
      dx = xs[7] ? {xs, 1'b0} - 9'd255 : 9'd255 - {xs, 1'b0};
      dy = ys[7] ? {ys, 1'b0} - 9'd255 : 9'd255 - {ys, 1'b0};
      sq = 17'(dx) * 17'(dx);
      n  = 18'd65025 - 18'(sq) - 18'(17'(dy) * 17'(dy));
      trial = 17'(res_ff) + 17'(bit_ff);
      bsum = 9'd128 + 9'(res_ff[15:1]);
   end

   assign ready_row = !is5 || (tx_ff == 3'd4);
   assign emit = wk_valid && ready_row && (!ov_ff || !rsp_stall);
   assign wk_pop = emit && (row_ff == 2'd3);
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0; tx_ff <= '0; busy_ff <= 1'b0; ov_ff <= 1'b0; step_ff <= '0;
      end else begin
         if (emit) begin
            ov_ff  <= 1'b1;
            row_ff <= row_ff + 2'd1;
            tx_ff  <= '0;
         end else if (!rsp_stall) begin
            ov_ff <= 1'b0;
         end
         if (wk_valid && is5 && tx_ff != 3'd4) begin
            if (!busy_ff) begin
               busy_ff <= 1'b1;
               step_ff <= '0;
               n_ff    <= n[17] || n == '0 ? 16'd0 : n[15:0];
               res_ff  <= '0;
               bit_ff  <= 16'h4000;
            end else if (step_ff == 4'd8) begin
               busy_ff <= 1'b0;
               blue_ff[tx_ff[1:0]] <= (n_ff == 16'd0 && res_ff == 16'd0) ? 8'd128
                                     : (bsum[8] ? 8'd255 : bsum[7:0]);
               tx_ff <= tx_ff + 3'd1;
            end else begin
               step_ff <= step_ff + 4'd1;
               bit_ff  <= bit_ff >> 2;
               if (17'(n_ff) >= trial) begin
                  n_ff   <= 16'(17'(n_ff) - trial);
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
            end
         end
      end
      if (emit) begin
         out_ff.row_index <= row_ff;
         out_ff.texel_0   <= tex[0];
         out_ff.texel_1   <= tex[1];
         out_ff.texel_2   <= tex[2];
         out_ff.texel_3   <= tex[3];
         out_ff.last_row  <= (row_ff == 2'd3);
      end
   end
endmodule
`default_nettype wire

### rtl/bc_block_decoder.sv
// A block passes the front register and a queue entry before the back stage registers its first row beat.
// Throughput: one row beat per cycle for BC1..BC4 while a block is queued and rsp_stall is low;
//   BC5 takes each texel of a row in turn through the shared bit-serial
//   square root before that row can be emitted.
// A 2-entry block queue separates classifier and row emitter.
// Reset: synchronous, active high; clears handshake state, format reg to BC1.
// ----------------------------------------------------------------------------
// bc_block_decoder: BC1..BC5 texture block decoder top level
// ----------------------------------------------------------------------------
`default_nettype none
module bc_block_decoder #(
   parameter int unsigned QDepth = bcd_pkg::QueueDepth
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire [2:0]           csr_data,
   input  wire                 req_valid,
   output logic                req_stall,
   input  bcd_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output bcd_pkg::rsp_type    rsp_data
);
   import bcd_pkg::*;

   logic [2:0] fmt_ff;
   logic       f_valid, f_stall, q_valid, q_pop;
   work_type   f_data, q_data;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) fmt_ff <= FMT_BC1;
      else if (csr_valid) fmt_ff <= csr_data;
   end

   bcd_front u_front (
      .clock, .reset, .fmt(fmt_ff), .req_valid, .req_stall, .req_data,
      .wk_valid(f_valid), .wk_stall(f_stall), .wk_data(f_data)
   );

   bcd_queue #(.Depth(QDepth)) u_queue (
      .clock, .reset, .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(q_valid), .out_pop(q_pop), .out_data(q_data)
   );

   bcd_back u_back (
      .clock, .reset, .wk_valid(q_valid), .wk_pop(q_pop), .wk_data(q_data),
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
`default_nettype wire
